// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ACD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ACD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/acd_pkg.sv
// ----------------------------------------------------------------------------
// ACF CAN decapsulator package
// Item types, frame offsets, status codes and the CAN FD size lookup.
// ----------------------------------------------------------------------------
package acd_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;

	localparam logic [15:0] AVTP_ETHERTYPE = 16'h22F0;
	localparam logic [7:0]  ACF_SUBTYPE    = 8'h05;
	localparam logic [6:0]  ACF_CAN_TYPE   = 7'h01;
	localparam logic [10:0] ACF_HDR_BYTES  = 11'd16;
	localparam logic [6:0]  CLASSIC_MAX    = 7'd8;

	localparam logic [10:0] POS_TYPE_HI   = 11'd12;
	localparam logic [10:0] POS_TYPE_LO   = 11'd13;
	localparam logic [10:0] POS_SUBTYPE   = 11'd14;
	localparam logic [10:0] POS_MSG_TYPE  = 11'd38;
	localparam logic [10:0] POS_QLEN      = 11'd39;
	localparam logic [10:0] POS_FLAGS     = 11'd40;
	localparam logic [10:0] POS_ID_FIRST  = 11'd50;
	localparam logic [10:0] POS_ID_LAST   = 11'd53;
	localparam logic [10:0] POS_PAYLOAD   = 11'd54;
	localparam logic [10:0] POS_MAX       = 11'd2047;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_NOT_AVTP  = 3'd1;
	localparam logic [2:0] STATUS_BAD_SUB   = 3'd2;
	localparam logic [2:0] STATUS_BAD_TYPE  = 3'd3;
	localparam logic [2:0] STATUS_BAD_FD    = 3'd4;
	localparam logic [2:0] STATUS_TRUNCATED = 3'd5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DESC    = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [5:0]  byte_index;
		logic [28:0] can_ident;
		logic        extended;
		logic        remote;
		logic        rate_switch;
		logic        fd_format;
		logic        error_state;
		logic [3:0]  length_code;
		logic [2:0]  status;
		logic        last;
	} result_item_t;

	// Returns {hit, code} for a CAN FD data length.
	function automatic logic [4:0] fd_lookup(input logic [6:0] len);
		logic [4:0] r;
		case (len) inside
			[7'd0:7'd8]: r = {1'b1, len[3:0]};
			7'd12:       r = {1'b1, 4'd9};
			7'd16:       r = {1'b1, 4'd10};
			7'd20:       r = {1'b1, 4'd11};
			7'd24:       r = {1'b1, 4'd12};
			7'd32:       r = {1'b1, 4'd13};
			7'd48:       r = {1'b1, 4'd14};
			7'd64:       r = {1'b1, 4'd15};
			default:     r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/acd_in_skid.sv
// ----------------------------------------------------------------------------
// ACF CAN decapsulator input stage
// Input register with a skid entry so that stall is driven from a register.
// ----------------------------------------------------------------------------
module acd_in_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	input  acd_pkg::frame_item_t frame,
	output logic                 frame_stall,
	input  logic                 take,
	output logic                 valid_s1,
	output acd_pkg::frame_item_t item_s1
);
	import acd_pkg::*;

	logic        skid_valid_q;
	frame_item_t skid_q;
	logic        accept;
	logic        s1_open;

	assign accept      = frame_valid && !skid_valid_q;
	assign s1_open     = !valid_s1 || take;
	assign frame_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (s1_open) begin
			valid_s1     <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_open) begin
			item_s1 <= skid_valid_q ? skid_q : frame;
		end else if (accept) begin
			skid_q <= frame;
		end
	end

endmodule

// File: rtl/acd_parse.sv
// ----------------------------------------------------------------------------
// ACF CAN decapsulator parser
// Holds the per-frame header state and forms the payload and descriptor
// results for the item in the input register.
// ----------------------------------------------------------------------------
module acd_parse #(
	parameter int MAX_PAYLOAD = acd_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  acd_pkg::frame_item_t  item,
	input  logic                  commit,
	output logic                  pay_hit,
	output acd_pkg::result_item_t pay_res,
	output acd_pkg::result_item_t desc_res
);
	import acd_pkg::*;

	localparam logic [10:0] CAP = 11'(MAX_PAYLOAD);

	logic [10:0] pos_q;
	logic [7:0]  type_high_q;
	logic [2:0]  err_q;
	logic [8:0]  qlen_q;
	logic [4:0]  flags_q;
	logic [28:0] ident_q;
	logic [6:0]  plen_q;

	logic [7:0]  b;
	logic [7:0]  type_high_n;
	logic [2:0]  err_n;
	logic [8:0]  qlen_n;
	logic [4:0]  flags_n;
	logic [28:0] ident_n;
	logic [6:0]  plen_n;
	logic [10:0] total;
	logic [10:0] over;
	logic [11:0] pay_end;
	logic [4:0]  fd_now;
	logic [4:0]  fd_fin;
	logic [2:0]  st;

	assign b = item.frame_byte;
	assign fd_now = fd_lookup(plen_q);

	always_comb begin
		type_high_n = type_high_q;
		err_n       = err_q;
		qlen_n      = qlen_q;
		flags_n     = flags_q;
		ident_n     = ident_q;
		plen_n      = plen_q;
		total       = {qlen_q, 2'b00};
		over        = total - ACF_HDR_BYTES;
		if (pos_q == POS_TYPE_HI) begin
			type_high_n = b;
		end
		if (pos_q == POS_TYPE_LO && {type_high_q, b} != AVTP_ETHERTYPE && err_q == STATUS_OK) begin
			err_n = STATUS_NOT_AVTP;
		end
		if (pos_q == POS_SUBTYPE && err_q == STATUS_OK && b != ACF_SUBTYPE) begin
			err_n = STATUS_BAD_SUB;
		end
		if (pos_q == POS_MSG_TYPE) begin
			qlen_n = {b[0], qlen_q[7:0]};
			if (err_q == STATUS_OK && b[7:1] != ACF_CAN_TYPE) begin
				err_n = STATUS_BAD_TYPE;
			end
		end
		if (pos_q == POS_QLEN) begin
			qlen_n = {qlen_q[8], b};
			total  = {qlen_n, 2'b00};
			over   = total - ACF_HDR_BYTES;
			if (total <= ACF_HDR_BYTES) begin
				plen_n = 7'd0;
			end else if (over > CAP) begin
				plen_n = CAP[6:0];
			end else begin
				plen_n = over[6:0];
			end
		end
		if (pos_q == POS_FLAGS) begin
			flags_n = b[4:0];
			if (err_q == STATUS_OK && b[1] && !fd_now[4]) begin
				err_n = STATUS_BAD_FD;
			end
		end
		if (pos_q >= POS_ID_FIRST && pos_q <= POS_ID_LAST) begin
			ident_n = {ident_q[20:0], b};
		end
	end

	assign pay_end = {1'b0, POS_PAYLOAD} + {5'd0, plen_n};
	assign pay_hit = pos_q >= POS_PAYLOAD && {1'b0, pos_q} < pay_end &&
		(err_n == STATUS_OK || err_n == STATUS_BAD_FD);
	assign fd_fin = fd_lookup(plen_n);

	always_comb begin
		pay_res            = '0;
		pay_res.kind       = KIND_PAYLOAD;
		pay_res.data_byte  = b;
		pay_res.byte_index = 6'(pos_q - POS_PAYLOAD);
	end

	always_comb begin
		st = err_n;
		if (st == STATUS_OK && ({1'b0, pos_q} + 12'd1) < pay_end) begin
			st = STATUS_TRUNCATED;
		end
		desc_res        = '0;
		desc_res.kind   = KIND_DESC;
		desc_res.status = st;
		desc_res.last   = 1'b1;
		if (st != STATUS_NOT_AVTP) begin
			desc_res.can_ident   = flags_n[3] ? ident_n : {18'd0, ident_n[10:0]};
			desc_res.extended    = flags_n[3];
			desc_res.remote      = flags_n[4];
			desc_res.rate_switch = flags_n[2];
			desc_res.fd_format   = flags_n[1];
			desc_res.error_state = flags_n[0];
			if (flags_n[1]) begin
				desc_res.length_code = fd_fin[3:0];
			end else begin
				desc_res.length_code = (plen_n <= CLASSIC_MAX) ? plen_n[3:0] : CLASSIC_MAX[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			type_high_q <= '0;
			err_q       <= '0;
			qlen_q      <= '0;
			flags_q     <= '0;
			ident_q     <= '0;
			plen_q      <= '0;
		end else if (commit) begin
			if (item.frame_end) begin
				pos_q       <= '0;
				type_high_q <= '0;
				err_q       <= '0;
				qlen_q      <= '0;
				flags_q     <= '0;
				ident_q     <= '0;
				plen_q      <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 11'd1;
				end
				type_high_q <= type_high_n;
				err_q       <= err_n;
				qlen_q      <= qlen_n;
				flags_q     <= flags_n;
				ident_q     <= ident_n;
				plen_q      <= plen_n;
			end
		end
	end

endmodule

// File: rtl/avtp_acf_can_decapsulator.sv
// ----------------------------------------------------------------------------
// AVTP ACF CAN decapsulator
// Parses an Ethernet frame carrying an ACF CAN message, byte by byte, into
// CAN payload items and one closing descriptor item per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle unless stalled. Results go from the
// input register to the result register. A byte that is both a payload byte
// and the last byte of its frame produces two items, payload then descriptor,
// and holds the input register between them, as the single result register
// moves at most one item per cycle. Input stall comes from a skid register.
module avtp_acf_can_decapsulator #(
	parameter int MAX_PAYLOAD = acd_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	output logic                  frame_stall,
	input  acd_pkg::frame_item_t  frame,
	output logic                  result_valid,
	input  logic                  result_stall,
	output acd_pkg::result_item_t result
);
	import acd_pkg::*;
	`include "assert_macros.svh"

	logic         valid_s1;
	frame_item_t  item_s1;
	logic         pay_hit;
	result_item_t pay_res;
	result_item_t desc_res;
	logic         phase_q;
	logic         result_valid_q;
	result_item_t result_q;
	logic         out_free;
	logic         emit_pay;
	logic         emit_desc;
	logic         load;
	logic         adv;

	acd_in_skid u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_valid(frame_valid),
		.frame      (frame),
		.frame_stall(frame_stall),
		.take       (adv),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	acd_parse #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.commit  (adv),
		.pay_hit (pay_hit),
		.pay_res (pay_res),
		.desc_res(desc_res)
	);

	assign out_free  = !result_valid_q || !result_stall;
	assign emit_pay  = valid_s1 && pay_hit && !phase_q;
	assign emit_desc = valid_s1 && item_s1.frame_end && !emit_pay;
	assign load      = out_free && (emit_pay || emit_desc);
	assign adv       = valid_s1 && out_free && !(emit_pay && item_s1.frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= load;
			if (valid_s1) begin
				phase_q <= emit_pay && item_s1.frame_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= emit_pay ? pay_res : desc_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ACD_ASSERT(a_skid_behind_s1, frame_stall, valid_s1, "skid item held with empty input register")
	`ACD_ASSERT(a_phase_on_last, phase_q, valid_s1 && item_s1.frame_end, "second result pending without a last byte")
	`ACD_ASSERT_NEXT(a_load_shows, load, result_valid_q, "loaded item not presented")
	`ACD_ASSERT(a_not_avtp_clean, result_valid_q && result_q.status == STATUS_NOT_AVTP, result_q.can_ident == 29'd0 && result_q.length_code == 4'd0, "non-AVTP descriptor carries fields")

endmodule

// File: tb/tb_avtp_acf_can_decapsulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AVTP ACF CAN decapsulator testbench
// Sends Ethernet frames byte by byte, some well formed and some corrupted or
// cut short, through the decapsulator. The CAN payload and descriptor items
// that come back are checked against a cycle-free model of the frame parser.
// Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_avtp_acf_can_decapsulator;
	import acd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_BYTES    = 90;

	class acf_can_scoreboard;
		logic [10:0] position;
		logic [7:0]  type_high;
		logic [2:0]  first_error;
		logic [8:0]  quadlets;
		logic [4:0]  flags;
		logic [28:0] ident;
		logic [6:0]  data_len;
		result_item_t pending[$];
		int mismatches;
		int payload_items;
		int descriptors;
		int status_count[6];

		function new();
			clear();
		endfunction

		function void clear();
			position = '0;
			type_high = '0;
			first_error = STATUS_OK;
			quadlets = '0;
			flags = '0;
			ident = '0;
			data_len = '0;
		endfunction

		static function logic [6:0] data_length(input logic [8:0] q);
			int total;
			total = int'(q) * 4;
			if (total <= int'(ACF_HDR_BYTES))
				return '0;
			if (total - int'(ACF_HDR_BYTES) > MAX_PAYLOAD_DEF)
				return 7'(MAX_PAYLOAD_DEF);
			return 7'(total - int'(ACF_HDR_BYTES));
		endfunction

		static function bit fd_code(input logic [6:0] len, output logic [3:0] code);
			int unsigned sizes[16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};
			code = '0;
			for (int i = 0; i < 16; i++) begin
				if (sizes[i] == len) begin
					code = 4'(i);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_byte(input frame_item_t it);
			result_item_t r;
			logic [7:0] b;
			logic [3:0] code;
			logic [2:0] st;
			int p;
			b = it.frame_byte;
			p = int'(position);
			if (p == POS_TYPE_HI)
				type_high = b;
			if (p == POS_TYPE_LO && {type_high, b} != AVTP_ETHERTYPE && first_error == STATUS_OK)
				first_error = STATUS_NOT_AVTP;
			if (p == POS_SUBTYPE && first_error == STATUS_OK && b != ACF_SUBTYPE)
				first_error = STATUS_BAD_SUB;
			if (p == POS_MSG_TYPE) begin
				quadlets[8] = b[0];
				if (first_error == STATUS_OK && b[7:1] != ACF_CAN_TYPE)
					first_error = STATUS_BAD_TYPE;
			end
			if (p == POS_QLEN) begin
				quadlets[7:0] = b;
				data_len = data_length(quadlets);
			end
			if (p == POS_FLAGS) begin
				flags = b[4:0];
				if (first_error == STATUS_OK && flags[1] && !fd_code(data_len, code))
					first_error = STATUS_BAD_FD;
			end
			if (p >= POS_ID_FIRST && p <= POS_ID_LAST)
				ident = {ident[20:0], b};
			if (p >= POS_PAYLOAD && p < int'(POS_PAYLOAD) + int'(data_len) &&
			    (first_error == STATUS_OK || first_error == STATUS_BAD_FD)) begin
				r = '0;
				r.kind = KIND_PAYLOAD;
				r.data_byte = b;
				r.byte_index = 6'(p - int'(POS_PAYLOAD));
				pending.push_back(r);
			end
			if (it.frame_end) begin
				r = '0;
				st = first_error;
				if (st == STATUS_OK && p + 1 < int'(POS_PAYLOAD) + int'(data_len))
					st = STATUS_TRUNCATED;
				r.kind = KIND_DESC;
				if (st != STATUS_NOT_AVTP) begin
					r.can_ident = flags[3] ? ident : {18'b0, ident[10:0]};
					r.extended = flags[3];
					r.remote = flags[4];
					r.rate_switch = flags[2];
					r.fd_format = flags[1];
					r.error_state = flags[0];
					if (flags[1]) begin
						void'(fd_code(data_len, code));
						r.length_code = code;
					end else begin
						r.length_code = (data_len <= CLASSIC_MAX) ? data_len[3:0]
						                                          : CLASSIC_MAX[3:0];
					end
				end
				r.status = st;
				r.last = 1'b1;
				pending.push_back(r);
				clear();
			end else if (position < POS_MAX) begin
				position = position + 11'd1;
			end
		endfunction

		function string show(input result_item_t r);
			return {$sformatf("kind %0d data %02h idx %0d id %08h ext %0d rtr %0d",
			                  r.kind, r.data_byte, r.byte_index, r.can_ident, r.extended,
			                  r.remote),
			        $sformatf(" brs %0d fdf %0d esi %0d dlc %0d st %0d last %0d",
			                  r.rate_switch, r.fd_format, r.error_state, r.length_code,
			                  r.status, r.last)};
		endfunction

		function void report(input string what, input result_item_t want,
		                     input result_item_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("tb: mismatch at %0t: %s", $realtime, what);
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		endfunction

		function void check_result(input result_item_t got);
			result_item_t want;
			if (pending.size() == 0) begin
				report("result item with nothing pending", '0, got);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
			    got.byte_index !== want.byte_index || got.can_ident !== want.can_ident ||
			    got.extended !== want.extended || got.remote !== want.remote ||
			    got.rate_switch !== want.rate_switch || got.fd_format !== want.fd_format ||
			    got.error_state !== want.error_state ||
			    got.length_code !== want.length_code || got.status !== want.status ||
			    got.last !== want.last)
				report("field mismatch", want, got);
			if (want.kind == KIND_DESC) begin
				descriptors++;
				status_count[want.status]++;
			end else begin
				payload_items++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         frame_valid;
	logic         frame_stall;
	frame_item_t  frame;
	logic         result_valid;
	logic         result_stall;
	result_item_t result;

	acf_can_scoreboard sb;
	logic [7:0] frame_buf[$];
	int idle_pct;
	int stall_pct;
	int bytes_driven;
	int frames_sent;
	int quiet_cycles;

	avtp_acf_can_decapsulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && frame_valid && !frame_stall)
			sb.note_byte(frame);
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		if (!arst_n || (frame_valid && !frame_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("tb: no item moved for %0d cycles, %0d results outstanding",
		         WATCHDOG_LIMIT, sb.pending.size());
		$display("tb: failure");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < idle_pct) begin
			frame_valid <= 1'b0;
			@(posedge clk);
		end
		frame_valid <= 1'b1;
		frame <= '{frame_byte: b, frame_end: e};
		bytes_driven++;
		do
			@(posedge clk);
		while (frame_stall);
	endtask

	// Bytes past the built frame are random filler.
	task automatic send_frame(input int n_bytes);
		for (int i = 0; i < n_bytes; i++)
			push_byte((i < frame_buf.size()) ? frame_buf[i] : 8'($urandom_range(255)),
			          i == n_bytes - 1);
		frames_sent++;
	endtask

	function automatic void build_acf_frame(input logic [4:0] flags, input logic [8:0] qlen,
	                                        input logic [28:0] ident, input int trailer);
		int plen;
		plen = int'(acf_can_scoreboard::data_length(qlen));
		frame_buf.delete();
		for (int i = 0; i < int'(POS_PAYLOAD) + plen + trailer; i++)
			frame_buf.push_back(8'($urandom_range(255)));
		frame_buf[POS_TYPE_HI] = AVTP_ETHERTYPE[15:8];
		frame_buf[POS_TYPE_LO] = AVTP_ETHERTYPE[7:0];
		frame_buf[POS_SUBTYPE] = ACF_SUBTYPE;
		frame_buf[POS_MSG_TYPE] = {ACF_CAN_TYPE, qlen[8]};
		frame_buf[POS_QLEN] = qlen[7:0];
		frame_buf[POS_FLAGS] = {frame_buf[POS_FLAGS][7:5], flags};
		frame_buf[POS_ID_FIRST] = {frame_buf[POS_ID_FIRST][7:5], ident[28:24]};
		frame_buf[POS_ID_FIRST + 1] = ident[23:16];
		frame_buf[POS_ID_FIRST + 2] = ident[15:8];
		frame_buf[POS_ID_LAST] = ident[7:0];
	endfunction

	task automatic run_directed();
		// Classic frame that ends on its last payload byte, with extreme byte values.
		build_acf_frame(5'h00, 9'd6, 29'h7FF, 0);
		for (int i = 0; i < 6; i++) begin
			frame_buf[i] = 8'hFF;
			frame_buf[i + 6] = 8'h00;
		end
		frame_buf[POS_PAYLOAD] = 8'h00;
		frame_buf[POS_PAYLOAD + 7] = 8'hFF;
		send_frame(frame_buf.size());
		build_acf_frame(5'h1F, 9'd20, 29'h1FFFFFFF, 2);
		send_frame(frame_buf.size());
		build_acf_frame(5'h08, 9'd0, 29'h0, 0);
		send_frame(frame_buf.size());
		// Standard identifier with high bits set, length capped at the maximum.
		build_acf_frame(5'h00, 9'h1FF, 29'h1FFFF800, 1);
		send_frame(frame_buf.size());
		// FD frame whose data length is not a legal FD size.
		build_acf_frame(5'h02, 9'd11, 29'($urandom), 0);
		send_frame(frame_buf.size());
		// Wrong ethertype and wrong subtype: the ethertype error is reported.
		build_acf_frame(5'h02, 9'd7, 29'($urandom), 0);
		frame_buf[POS_TYPE_LO] ^= 8'h01;
		frame_buf[POS_SUBTYPE] = 8'h00;
		send_frame(frame_buf.size());
		build_acf_frame(5'h0A, 9'd11, 29'($urandom), 0);
		frame_buf[POS_SUBTYPE] = 8'h06;
		frame_buf[POS_MSG_TYPE] ^= 8'h04;
		send_frame(frame_buf.size());
		// Bad message type hides the bad FD size and suppresses the payload.
		build_acf_frame(5'h02, 9'd11, 29'($urandom), 0);
		frame_buf[POS_MSG_TYPE] = 8'hFE;
		send_frame(frame_buf.size());
		build_acf_frame(5'h04, 9'd8, 29'($urandom), 0);
		send_frame(60);
		send_frame(1);
		send_frame(13);
		// Long frame with filler bytes well past its payload.
		build_acf_frame(5'h10, 9'd5, 29'($urandom), 0);
		send_frame(100);
	endtask

	task automatic random_frame();
		logic [4:0] flags;
		logic [8:0] qlen;
		logic [28:0] ident;
		int pick;
		int fd_quadlets[10] = '{4, 5, 6, 7, 8, 9, 10, 12, 16, 20};
		flags = 5'($urandom);
		ident = 29'($urandom);
		pick = $urandom_range(99);
		if (flags[1] && pick < 60)
			qlen = 9'(fd_quadlets[$urandom_range(9)]);
		else if (pick < 80)
			qlen = 9'($urandom_range(4, 20));
		else if (pick < 90)
			qlen = 9'($urandom_range(0, 3));
		else
			qlen = 9'($urandom_range(21, 511));
		build_acf_frame(flags, qlen, ident, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
		pick = $urandom_range(99);
		if (pick >= 70 && pick < 78)
			frame_buf[$urandom_range(12, 13)] ^= 8'($urandom_range(1, 255));
		else if (pick >= 78 && pick < 84)
			frame_buf[POS_SUBTYPE] ^= 8'($urandom_range(1, 255));
		else if (pick >= 84 && pick < 90)
			frame_buf[POS_MSG_TYPE] ^= 8'($urandom_range(1, 127) << 1);
		if (pick >= 70 && pick < 90 && $urandom_range(1) == 1)
			frame_buf[$urandom_range(13, 40)] ^= 8'($urandom_range(1, 255));
		if (pick >= 90)
			send_frame($urandom_range(1, frame_buf.size() - 1));
		else
			send_frame(frame_buf.size());
	endtask

	initial begin
		int idle_by_phase[4];
		int stall_by_phase[4];
		int target;
		idle_by_phase = '{0, 82, 0, 33};
		stall_by_phase = '{0, 0, 82, 33};
		arst_n = 1'b0;
		frame_valid = 1'b0;
		frame = '0;
		idle_pct = 0;
		stall_pct = 0;
		bytes_driven = 0;
		frames_sent = 0;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			target = bytes_driven + PHASE_BYTES;
			while (bytes_driven < target)
				random_frame();
		end
		frame_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d frames of %0d bytes gave %0d payload items and %0d descriptors",
		         frames_sent, bytes_driven, sb.payload_items, sb.descriptors);
		$display("tb: descriptors ok %0d, not avtp %0d, bad subtype %0d, bad type %0d, %s %0d, %s %0d",
		         sb.status_count[STATUS_OK], sb.status_count[STATUS_NOT_AVTP],
		         sb.status_count[STATUS_BAD_SUB], sb.status_count[STATUS_BAD_TYPE],
		         "bad fd size", sb.status_count[STATUS_BAD_FD],
		         "truncated", sb.status_count[STATUS_TRUNCATED]);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/acd_pkg.sv
rtl/acd_in_skid.sv
rtl/acd_parse.sv
rtl/avtp_acf_can_decapsulator.sv
tb/tb_avtp_acf_can_decapsulator.sv
